// File: hw/rtl/gap_run_chunk_snapper_defines.svh
// Shared assertion macros for the gap run chunk snapper.
`ifndef GAP_RUN_CHUNK_SNAPPER_DEFINES_SVH
`define GAP_RUN_CHUNK_SNAPPER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GRCS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, disabled while rst is high.
`define GRCS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// File: hw/rtl/grcs_pkg.sv
package grcs_pkg;

   localparam logic [7:0]  GAP_BYTE    = 8'h3F;
   localparam logic [23:0] POS_MAX     = 24'hFFFFFF;
   localparam logic [24:0] CNT_MAX     = 25'h1FFFFFF;
   localparam logic [15:0] CHUNK_RESET = 16'd195;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 25;
   localparam logic [CSR_IDX_W-1:0] REG_CHUNK_SIZE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FILE_LENGTH = 1'd1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam int REM_STEPS = 25;
   localparam int REM_CNT_W = 5;

   localparam int RSP_DATA_W = 128;

   typedef struct packed {
      logic        has_range;
      logic        has_summary;
      logic [23:0] begin_pos;
      logic [24:0] end_pos;
      logic [23:0] runs;
      logic [24:0] gaps;
   } cmd_type;

   typedef struct packed {
      logic        start;
      logic [24:0] dividend;
      logic [15:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] rem;
   } rem_rsp_type;

endpackage

// File: hw/rtl/grcs_front.sv
module grcs_front #(
   parameter logic [24:0] SAT_CAP = 25'd16777216
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   output logic              push,
   output grcs_pkg::cmd_type cmd,
   input  logic              full
);

   logic [23:0] position_ff, position_in;
   logic        run_open_ff, run_open_in;
   logic [23:0] run_begin_ff, run_begin_in;
   logic [23:0] run_cnt_ff, run_cnt_in;
   logic [24:0] gap_cnt_ff, gap_cnt_in;

   logic        beat;
   logic        gap;
   logic        close_now;
   logic        has_range;
   logic [23:0] a_pos;
   logic [24:0] b_pos;
   logic [24:0] span;
   logic [25:0] gap_sum;
   logic [24:0] gap_next;
   logic [23:0] run_next;

   assign req_tready = !full;
   assign beat       = req_tvalid && !full;
   assign gap        = (req_tdata == grcs_pkg::GAP_BYTE);
   assign close_now  = !gap && run_open_ff;
   assign has_range  = close_now || (req_tlast && (run_open_ff || gap));
   assign a_pos      = run_open_ff ? run_begin_ff : position_ff;
   assign b_pos      = close_now ? {1'b0, position_ff} : {1'b0, position_ff} + 25'd1;
   assign span       = b_pos - {1'b0, a_pos};
   assign gap_sum    = {1'b0, gap_cnt_ff} + {1'b0, span};

   always_comb begin
      if (!has_range) begin
         gap_next = gap_cnt_ff;
      end else if (gap_sum > {1'b0, SAT_CAP}) begin
         gap_next = SAT_CAP;
      end else begin
         gap_next = gap_sum[24:0];
      end
      if (has_range && (run_cnt_ff != grcs_pkg::POS_MAX)) begin
         run_next = run_cnt_ff + 24'd1;
      end else begin
         run_next = run_cnt_ff;
      end
   end

   assign push = beat && (close_now || req_tlast);

   always_comb begin
      cmd.has_range   = has_range;
      cmd.has_summary = req_tlast;
      cmd.begin_pos   = a_pos;
      cmd.end_pos     = b_pos;
      cmd.runs        = run_next;
      cmd.gaps        = gap_next;
   end

   always_comb begin
      position_in  = position_ff;
      run_open_in  = run_open_ff;
      run_begin_in = run_begin_ff;
      run_cnt_in   = run_cnt_ff;
      gap_cnt_in   = gap_cnt_ff;
      if (beat) begin
         if (req_tlast) begin
            position_in  = '0;
            run_open_in  = 1'b0;
            run_begin_in = '0;
            run_cnt_in   = '0;
            gap_cnt_in   = '0;
         end else begin
            if (position_ff != grcs_pkg::POS_MAX) begin
               position_in = position_ff + 24'd1;
            end
            if (gap && !run_open_ff) begin
               run_open_in  = 1'b1;
               run_begin_in = position_ff;
            end else if (close_now) begin
               run_open_in = 1'b0;
            end
            run_cnt_in = run_next;
            gap_cnt_in = gap_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         run_open_ff  <= 1'b0;
         run_begin_ff <= '0;
         run_cnt_ff   <= '0;
         gap_cnt_ff   <= '0;
      end else begin
         position_ff  <= position_in;
         run_open_ff  <= run_open_in;
         run_begin_ff <= run_begin_in;
         run_cnt_ff   <= run_cnt_in;
         gap_cnt_ff   <= gap_cnt_in;
      end
   end

endmodule

// File: hw/rtl/grcs_fifo.sv
module grcs_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  grcs_pkg::cmd_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output grcs_pkg::cmd_type rd_data,
   output logic              empty
);

   grcs_pkg::cmd_type                    slot_ff [grcs_pkg::FIFO_DEPTH];
   logic [grcs_pkg::FIFO_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [grcs_pkg::FIFO_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [grcs_pkg::FIFO_CNT_W-1:0]      count_ff, count_in;
   logic                                 do_wr;
   logic                                 do_rd;

   assign full    = (count_ff == grcs_pkg::FIFO_CNT_W'(grcs_pkg::FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/grcs_rem.sv
module grcs_rem (
   input  logic                  clock,
   input  logic                  reset,
   input  grcs_pkg::rem_req_type req,
   output grcs_pkg::rem_rsp_type rsp
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [grcs_pkg::REM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [24:0]                    dvd_ff, dvd_in;
   logic [15:0]                    div_ff, div_in;
   logic [15:0]                    rem_ff, rem_in;
   logic [16:0]                    trial;
   logic [16:0]                    diff;

   assign trial = {rem_ff, dvd_ff[24]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = req.dividend;
         div_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, div_ff}) ? diff[15:0] : trial[15:0];
         dvd_in = {dvd_ff[23:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == grcs_pkg::REM_CNT_W'(grcs_pkg::REM_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

endmodule

// File: hw/rtl/grcs_back.sv
module grcs_back #(
   parameter logic [24:0] SAT_CAP = 25'd16777216
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [grcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [grcs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  grcs_pkg::cmd_type                   rd_data,
   input  logic                                empty,
   output logic                                rd_en,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [grcs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);

   typedef enum logic [7:0] {
      ST_IDLE       = 8'b0000_0001,
      ST_START_A    = 8'b0000_0010,
      ST_WAIT_A     = 8'b0000_0100,
      ST_START_B    = 8'b0000_1000,
      ST_WAIT_B     = 8'b0001_0000,
      ST_CLIP       = 8'b0010_0000,
      ST_SEND_RANGE = 8'b0100_0000,
      ST_SEND_SUM   = 8'b1000_0000
   } back_state_type;

   back_state_type                      state_ff, state_in;
   grcs_pkg::cmd_type                   cmd_ff, cmd_in;
   logic [15:0]                         chunk_ff, chunk_in;
   logic [24:0]                         flen_ff, flen_in;
   logic [23:0]                         sa_ff, sa_in;
   logic [24:0]                         sb_ff, sb_in;
   logic [24:0]                         len_ff, len_in;
   logic [24:0]                         refetch_ff, refetch_in;
   logic                                valid_ff, valid_in;
   logic [grcs_pkg::RSP_DATA_W-1:0]     data_ff, data_in;
   logic                                user_ff, user_in;
   logic                                last_ff, last_in;

   grcs_pkg::rem_req_type               rem_req;
   grcs_pkg::rem_rsp_type               rem_rsp;

   logic [15:0]                         divisor;
   logic                                out_free;
   logic [24:0]                         sb_clip;
   logic [24:0]                         span;
   logic [25:0]                         refetch_sum;
   logic [24:0]                         refetch_next;

   assign divisor  = (chunk_ff == '0) ? 16'd1 : chunk_ff;
   assign out_free = !valid_ff || rsp_tready;
   assign rd_en    = (state_ff == ST_IDLE) && !empty;

   always_comb begin
      rem_req.start    = (state_ff == ST_START_A) || (state_ff == ST_START_B);
      rem_req.dividend = (state_ff == ST_START_A) ? {1'b0, cmd_ff.begin_pos} : cmd_ff.end_pos;
      rem_req.divisor  = divisor;
   end

   grcs_rem u_rem (
      .clock (clock),
      .reset (reset),
      .req   (rem_req),
      .rsp   (rem_rsp)
   );

   assign sb_clip     = (sb_ff > flen_ff) ? flen_ff : sb_ff;
   assign span        = (sb_clip > {1'b0, sa_ff}) ? sb_clip - {1'b0, sa_ff} : '0;
   assign refetch_sum = {1'b0, refetch_ff} + {1'b0, len_ff};
   assign refetch_next = (refetch_sum > {1'b0, SAT_CAP}) ? SAT_CAP : refetch_sum[24:0];

   always_comb begin
      chunk_in = chunk_ff;
      flen_in  = flen_ff;
      if (csr_we) begin
         case (csr_index)
            grcs_pkg::REG_CHUNK_SIZE: begin
               chunk_in = csr_wdata[15:0];
            end
            grcs_pkg::REG_FILE_LENGTH: begin
               flen_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      sa_in      = sa_ff;
      sb_in      = sb_ff;
      len_in     = len_ff;
      refetch_in = refetch_ff;
      valid_in   = valid_ff && !rsp_tready;
      data_in    = data_ff;
      user_in    = user_ff;
      last_in    = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               cmd_in   = rd_data;
               state_in = rd_data.has_range ? ST_START_A : ST_SEND_SUM;
            end
         end
         ST_START_A: begin
            state_in = ST_WAIT_A;
         end
         ST_WAIT_A: begin
            if (rem_rsp.done) begin
               sa_in    = cmd_ff.begin_pos - {8'd0, rem_rsp.rem};
               state_in = ST_START_B;
            end
         end
         ST_START_B: begin
            state_in = ST_WAIT_B;
         end
         ST_WAIT_B: begin
            if (rem_rsp.done) begin
               sb_in    = (rem_rsp.rem == '0) ? cmd_ff.end_pos :
                          cmd_ff.end_pos + {9'd0, divisor} - {9'd0, rem_rsp.rem};
               state_in = ST_CLIP;
            end
         end
         ST_CLIP: begin
            len_in   = (span > SAT_CAP) ? SAT_CAP : span;
            state_in = ST_SEND_RANGE;
         end
         ST_SEND_RANGE: begin
            if (out_free) begin
               valid_in   = 1'b1;
               data_in    = {5'd0, 25'd0, 25'd0, 24'd0, len_ff, sa_ff};
               user_in    = 1'b0;
               last_in    = !cmd_ff.has_summary;
               refetch_in = refetch_next;
               state_in   = cmd_ff.has_summary ? ST_SEND_SUM : ST_IDLE;
            end
         end
         ST_SEND_SUM: begin
            if (out_free) begin
               valid_in   = 1'b1;
               data_in    = {5'd0, refetch_ff, cmd_ff.gaps, cmd_ff.runs, 25'd0, 24'd0};
               user_in    = 1'b1;
               last_in    = 1'b1;
               refetch_in = '0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      sa_ff   <= sa_in;
      sb_ff   <= sb_in;
      len_ff  <= len_in;
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         chunk_ff   <= grcs_pkg::CHUNK_RESET;
         flen_ff    <= '0;
         refetch_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chunk_ff   <= chunk_in;
         flen_ff    <= flen_in;
         refetch_ff <= refetch_in;
         valid_ff   <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: hw/rtl/gap_run_chunk_snapper.sv
// Channel   Dir  Beat                         Carries
// req_      in   one file byte                data_byte, final_byte on tlast
// rsp_      out  one range or summary record  fields in tdata, kind on tuser
// csr_      in   one register write           chunk_size, file_length
//
// Front takes one byte per cycle while its 4-entry command queue has room.
// A command with a range takes the back through two 25-step passes of the shared
// remainder unit with their start and wait steps, a clip step and the send.
// A summary alone goes from idle straight to its send; after a range it follows the range's send.
// Reset is synchronous: scan state, totals, queue and registers go to defaults.
// A low rsp_tready holds the result register; the queue fills and req_tready drops.
module gap_run_chunk_snapper #(
   parameter longint unsigned MAX_FILE_BYTES = 64'd16777216
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // data_byte
   input  logic                                req_tlast,   // final_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // range_start[23:0], range_length[48:24], runs_total[72:49],
   // gap_bytes_total[97:73], refetch_bytes_total[122:98], zero pad
   output logic [grcs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,   // record_kind
   output logic                                rsp_tlast,   // end_of_burst
   input  logic                                csr_we,
   input  logic [grcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [grcs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [24:0] SAT_CAP =
      (MAX_FILE_BYTES < 64'(grcs_pkg::CNT_MAX)) ? MAX_FILE_BYTES[24:0] : grcs_pkg::CNT_MAX;

   grcs_pkg::cmd_type push_cmd;
   grcs_pkg::cmd_type pop_cmd;
   logic              push;
   logic              full;
   logic              pop;
   logic              empty;

   grcs_front #(
      .SAT_CAP (SAT_CAP)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .cmd        (push_cmd),
      .full       (full)
   );

   grcs_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (push_cmd),
      .full    (full),
      .rd_en   (pop),
      .rd_data (pop_cmd),
      .empty   (empty)
   );

   grcs_back #(
      .SAT_CAP (SAT_CAP)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rd_data    (pop_cmd),
      .empty      (empty),
      .rd_en      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hw/rtl/grcs_checker.sv
`include "gap_run_chunk_snapper_defines.svh"

module grcs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [grcs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);

   `GRCS_ASSERT_NXT(a_reset_drops_valid, clock, 1'b0, reset, !rsp_tvalid)
   `GRCS_ASSERT_NXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `GRCS_ASSERT_IMP(a_summary_ends_burst, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)
   `GRCS_ASSERT_IMP(a_range_no_totals, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[122:49] == '0)
   `GRCS_ASSERT_IMP(a_summary_no_range, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[48:0] == '0)

endmodule

bind gap_run_chunk_snapper grcs_checker u_grcs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: bench/tb_gap_run_chunk_snapper.sv
`timescale 1ns / 100ps

module tb_gap_run_chunk_snapper;

   localparam longint unsigned LENGTH_CAP = 64'd16777216;
   localparam int LATENCY = 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 1300;
   localparam int PLAN_ROWS = 32;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic        kind;
      logic [23:0] start;
      logic [24:0] length;
      logic [23:0] runs;
      logic [24:0] gaps;
      logic [24:0] refetch;
      logic        last;
   } snap_rec_type;

   typedef enum logic {ROW_BYTE, ROW_WRITE} row_op_type;

   typedef struct packed {
      row_op_type                       op;
      logic [grcs_pkg::CSR_IDX_W-1:0]   idx;
      logic [grcs_pkg::CSR_DATA_W-1:0]  val;
      logic [7:0]                       data;
      logic                             fin;
      logic [1:0]                       n_typed;
      snap_rec_type                     t0;
      snap_rec_type                     t1;
   } plan_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [7:0]                        req_tdata = '0;   // data_byte
   logic                              req_tlast = 1'b0; // final_byte
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // range_start, range_length, runs_total, gap_bytes_total, refetch_bytes_total
   logic [grcs_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              rsp_tuser;        // record_kind
   logic                              rsp_tlast;        // end_of_burst
   logic                              csr_we = 1'b0;
   logic [grcs_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [grcs_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   logic [15:0]  chunk_size = grcs_pkg::CHUNK_RESET;
   logic [24:0]  file_length = '0;
   logic [23:0]  position = '0;
   logic         run_open = 1'b0;
   logic [23:0]  run_begin = '0;
   logic [23:0]  run_count = '0;
   logic [24:0]  gap_count = '0;
   logic [24:0]  refetch_count = '0;

   snap_rec_type records_due[$];
   snap_rec_type step_records[$];
   snap_rec_type want;
   plan_row_type plan[PLAN_ROWS];
   int           mismatches = 0;
   int           cycle_count = 0;
   int           items_sent = 0;
   int           hold_requests = 0;
   bit           quiet = 1'b0;

   always #5 clock = ~clock;

   gap_run_chunk_snapper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   function automatic snap_rec_type range_rec(longint unsigned start, longint unsigned len,
                                              bit last);
      snap_rec_type r;
      r = '0;
      r.start = 24'(start);
      r.length = 25'(len);
      r.last = last;
      return r;
   endfunction

   function automatic snap_rec_type summary_rec(longint unsigned runs, longint unsigned gaps,
                                                longint unsigned refetch, bit last);
      snap_rec_type r;
      r = '0;
      r.kind = 1'b1;
      r.runs = 24'(runs);
      r.gaps = 25'(gaps);
      r.refetch = 25'(refetch);
      r.last = last;
      return r;
   endfunction

   function automatic longint unsigned capped(longint unsigned v);
      return (v > LENGTH_CAP) ? LENGTH_CAP : v;
   endfunction

   function automatic plan_row_type byte_row(logic [7:0] d, logic fin, logic [1:0] n,
                                             snap_rec_type a, snap_rec_type b);
      plan_row_type r;
      r = '0;
      r.op = ROW_BYTE;
      r.data = d;
      r.fin = fin;
      r.n_typed = n;
      r.t0 = a;
      r.t1 = b;
      return r;
   endfunction

   function automatic plan_row_type write_row(logic [grcs_pkg::CSR_IDX_W-1:0] idx,
                                              logic [grcs_pkg::CSR_DATA_W-1:0] val);
      plan_row_type r;
      r = '0;
      r.op = ROW_WRITE;
      r.idx = idx;
      r.val = val;
      return r;
   endfunction

   // close the open run at offset b, exclusive
   function automatic snap_rec_type close_run(longint unsigned b);
      longint unsigned c, a, lo, hi, len;
      c = (chunk_size == 16'd0) ? 64'd1 : 64'(chunk_size);
      a = 64'(run_begin);
      lo = (a / c) * c;
      hi = ((b + c - 64'd1) / c) * c;
      if (hi > 64'(file_length)) hi = 64'(file_length);
      len = capped((hi > lo) ? hi - lo : 64'd0);
      gap_count = 25'(capped(64'(gap_count) + ((b > a) ? b - a : 64'd0)));
      refetch_count = 25'(capped(64'(refetch_count) + len));
      if (run_count != grcs_pkg::POS_MAX) run_count = run_count + 24'd1;
      run_open = 1'b0;
      return range_rec(lo, len, 1'b0);
   endfunction

   function automatic void scan_byte(logic [7:0] d, logic fin);
      snap_rec_type tail;
      step_records.delete();
      if (d == grcs_pkg::GAP_BYTE && !run_open) begin
         run_open = 1'b1;
         run_begin = position;
      end else if (d != grcs_pkg::GAP_BYTE && run_open) begin
         step_records.push_back(close_run(64'(position)));
      end
      if (fin) begin
         if (run_open) step_records.push_back(close_run(64'(position) + 64'd1));
         step_records.push_back(summary_rec(64'(run_count), 64'(gap_count),
                                            64'(refetch_count), 1'b0));
         position = '0;
         run_open = 1'b0;
         run_begin = '0;
         run_count = '0;
         gap_count = '0;
         refetch_count = '0;
      end else if (position != grcs_pkg::POS_MAX) begin
         position = position + 24'd1;
      end
      if (step_records.size() > 0) begin
         tail = step_records.pop_back();
         tail.last = 1'b1;
         step_records.push_back(tail);
      end
   endfunction

   function automatic int draw_pause();
      return quiet ? 0 : int'($urandom_range(0, 9));
   endfunction

   task automatic hand_over(logic [7:0] d, logic fin);
      int gap;
      gap = draw_pause();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= fin;
      do @(posedge clock); while (!req_tready);
      scan_byte(d, fin);
   endtask

   task automatic send_byte(logic [7:0] d, logic fin);
      hand_over(d, fin);
      foreach (step_records[k]) records_due.push_back(step_records[k]);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (records_due.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(logic [grcs_pkg::CSR_IDX_W-1:0] idx,
                            logic [grcs_pkg::CSR_DATA_W-1:0] val);
      drain();
      csr_index <= idx;
      csr_wdata <= val;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == grcs_pkg::REG_CHUNK_SIZE) chunk_size = val[15:0];
      else if (idx == grcs_pkg::REG_FILE_LENGTH) file_length = val;
   endtask

   task automatic send_file(int len, int pct, bit alternate);
      logic [7:0] d;
      for (int j = 0; j < len; j++) begin
         if (alternate) d = j[0] ? 8'h78 : grcs_pkg::GAP_BYTE;
         else if ($urandom_range(0, 99) < pct) d = grcs_pkg::GAP_BYTE;
         else d = 8'($urandom_range(0, 255));
         send_byte(d, j == len - 1);
      end
   endtask

   task automatic reconfigure();
      int pick;
      logic [15:0] ck;
      logic [24:0] fl;
      pick = $urandom_range(0, 3);
      case ($urandom_range(0, 7))
         0: ck = 16'd0;
         1: ck = 16'd1;
         2: ck = 16'hFFFF;
         3: ck = grcs_pkg::CHUNK_RESET;
         4: ck = 16'($urandom);
         default: ck = 16'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 7))
         0: fl = 25'd0;
         1: fl = 25'd16777216;
         2: fl = 25'h1FFFFFF;
         3: fl = 25'($urandom);
         default: fl = 25'($urandom_range(0, 150));
      endcase
      if (pick != 1) write_reg(grcs_pkg::REG_CHUNK_SIZE, {9'($urandom), ck});
      if (pick != 0) write_reg(grcs_pkg::REG_FILE_LENGTH, fl);
   endtask

   task automatic compare_field(string name, logic [24:0] w, logic [24:0] g);
      if (g !== w) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, w, g);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (records_due.size() == 0) begin
            $display("%0t: unexpected record, kind %0h data %0h", $time, rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = records_due.pop_front();
            compare_field("record_kind", 25'(want.kind), 25'(rsp_tuser));
            compare_field("range_start", 25'(want.start), 25'(rsp_tdata[23:0]));
            compare_field("range_length", want.length, rsp_tdata[48:24]);
            compare_field("runs_total", 25'(want.runs), 25'(rsp_tdata[72:49]));
            compare_field("gap_bytes_total", want.gaps, rsp_tdata[97:73]);
            compare_field("refetch_bytes_total", want.refetch, rsp_tdata[122:98]);
            compare_field("end_of_burst", 25'(want.last), 25'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_gap_run_chunk_snapper: errors");
         $finish;
      end
   end

   initial begin : sink
      int w;
      int holds_done;
      holds_done = 0;
      wait (reset == 1'b0);
      forever begin
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         w = draw_pause();
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      int pct;
      bit held;
      held = 1'b0;
      plan[0]  = byte_row("A", 1'b1, 2'd1, summary_rec(0, 0, 0, 1'b1), '0);
      plan[1]  = byte_row(grcs_pkg::GAP_BYTE, 1'b1, 2'd2, range_rec(0, 0, 1'b0),
                          summary_rec(1, 1, 0, 1'b1));
      plan[2]  = write_row(grcs_pkg::REG_FILE_LENGTH, 25'h1FFFFFF);
      plan[3]  = byte_row("b", 1'b0, 2'd0, '0, '0);
      plan[4]  = byte_row(grcs_pkg::GAP_BYTE, 1'b1, 2'd2, range_rec(0, 195, 1'b0),
                          summary_rec(1, 1, 195, 1'b1));
      plan[5]  = write_row(grcs_pkg::REG_CHUNK_SIZE, 25'd0);
      plan[6]  = byte_row(grcs_pkg::GAP_BYTE, 1'b0, 2'd0, '0, '0);
      plan[7]  = byte_row(grcs_pkg::GAP_BYTE, 1'b0, 2'd0, '0, '0);
      plan[8]  = byte_row("x", 1'b0, 2'd1, range_rec(0, 2, 1'b1), '0);
      plan[9]  = byte_row(grcs_pkg::GAP_BYTE, 1'b1, 2'd2, range_rec(3, 1, 1'b0),
                          summary_rec(2, 3, 3, 1'b1));
      plan[10] = write_row(grcs_pkg::REG_CHUNK_SIZE, 25'h1FFFFFF);
      plan[11] = byte_row(8'h00, 1'b0, 2'd0, '0, '0);
      plan[12] = byte_row(grcs_pkg::GAP_BYTE, 1'b0, 2'd0, '0, '0);
      plan[13] = byte_row(8'hFF, 1'b0, 2'd1, range_rec(0, 65535, 1'b1), '0);
      plan[14] = byte_row(8'h3E, 1'b0, 2'd0, '0, '0);
      plan[15] = byte_row(8'h40, 1'b1, 2'd1, summary_rec(1, 1, 65535, 1'b1), '0);
      plan[16] = write_row(grcs_pkg::REG_FILE_LENGTH, 25'd3);
      plan[17] = write_row(grcs_pkg::REG_CHUNK_SIZE, 25'd2);
      plan[18] = byte_row("a", 1'b0, 2'd0, '0, '0);
      plan[19] = byte_row("b", 1'b0, 2'd0, '0, '0);
      plan[20] = byte_row("c", 1'b0, 2'd0, '0, '0);
      plan[21] = byte_row("d", 1'b0, 2'd0, '0, '0);
      plan[22] = byte_row(grcs_pkg::GAP_BYTE, 1'b0, 2'd0, '0, '0);
      plan[23] = byte_row(8'hC0, 1'b1, 2'd2, range_rec(4, 0, 1'b0),
                          summary_rec(1, 1, 0, 1'b1));
      plan[24] = write_row(grcs_pkg::REG_FILE_LENGTH, 25'd16777216);
      plan[25] = write_row(grcs_pkg::REG_CHUNK_SIZE, 25'd5);
      plan[26] = byte_row(grcs_pkg::GAP_BYTE, 1'b0, 2'd0, '0, '0);
      plan[27] = byte_row(grcs_pkg::GAP_BYTE, 1'b0, 2'd0, '0, '0);
      plan[28] = byte_row(grcs_pkg::GAP_BYTE, 1'b1, 2'd0, '0, '0);
      plan[29] = byte_row("z", 1'b0, 2'd0, '0, '0);
      plan[30] = byte_row(grcs_pkg::GAP_BYTE, 1'b0, 2'd0, '0, '0);
      plan[31] = byte_row("Q", 1'b1, 2'd0, '0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (plan[i].op == ROW_WRITE) begin
            write_reg(plan[i].idx, plan[i].val);
         end else begin
            hand_over(plan[i].data, plan[i].fin);
            if (plan[i].n_typed == 2'd0) begin
               foreach (step_records[k]) records_due.push_back(step_records[k]);
            end else begin
               records_due.push_back(plan[i].t0);
               if (plan[i].n_typed == 2'd2) records_due.push_back(plan[i].t1);
            end
         end
      end

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) reconfigure();
         quiet = ($urandom_range(0, 5) == 0);
         if (!held && items_sent > 400) begin
            // stall the result side and keep offering closing bytes
            held = 1'b1;
            quiet = 1'b1;
            hold_requests++;
            send_file(30, 0, 1'b1);
            drain();
         end else begin
            case ($urandom_range(0, 9))
               0: pct = 0;
               1: pct = 100;
               2, 3: pct = 20;
               4, 5, 6: pct = 50;
               default: pct = 80;
            endcase
            send_file(($urandom_range(0, 9) == 0) ? int'($urandom_range(40, 120))
                                                  : int'($urandom_range(1, 30)),
                      pct, 1'b0);
         end
      end

      drain();
      if (mismatches == 0 && records_due.size() == 0) begin
         $display("tb_gap_run_chunk_snapper: clean");
      end else begin
         $display("tb_gap_run_chunk_snapper: errors");
      end
      $finish;
   end

endmodule
